@@ design/pdq_pkg.sv @@
// Shared types and codes for the priority dispatch queue.
`default_nettype none

package pdq_pkg;

    // Request commands
    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_POP    = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_QFULL = 2'd1,
        ST_CFULL = 2'd2,
        ST_EMPTY = 2'd3
    } result_code_t;

    // Stored task payload
    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
        logic [31:0] ts;
    } entry_t;

    // Best-so-far candidate passed down the queue cells
    typedef struct packed {
        logic   valid;
        entry_t ent;
    } cand_t;

    // Queue cell controls, broadcast to every cell
    typedef struct packed {
        logic add;
        logic remove;
    } qctl_t;

    // Mark cell controls, decoded per cell
    typedef struct packed {
        logic set;
        logic clr;
    } mctl_t;

endpackage

`default_nettype wire

@@ design/pdq_qcell.sv @@
// Queue cell: one stored task plus one stage of the best-entry search chain.
`default_nettype none

module pdq_qcell #(
    parameter int IDX_W    = 4,
    parameter int CNT_W    = 5,
    parameter int CELL_IDX = 0
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pdq_pkg::qctl_t        ctl,
    input  wire logic [CNT_W-1:0]      count,
    input  wire logic [IDX_W-1:0]      rm_idx,
    input  wire pdq_pkg::entry_t       new_entry,
    input  wire logic                  nb_valid,
    input  wire pdq_pkg::entry_t       nb_entry,
    input  wire pdq_pkg::cand_t        cand_in,
    input  wire logic [IDX_W-1:0]      cand_in_idx,
    output logic                       valid,
    output pdq_pkg::entry_t            entry,
    output pdq_pkg::cand_t             cand_out,
    output logic [IDX_W-1:0]           cand_out_idx
);

    logic            valid_reg, valid_next;
    pdq_pkg::entry_t entry_reg, entry_next;
    logic            cand_valid_reg, cand_valid_next;
    pdq_pkg::entry_t cand_ent_reg, cand_ent_next;
    logic [IDX_W-1:0] cand_idx_reg, cand_idx_next;
    logic            better;

    // Entry storage: load at the fill position, shift down on removal
    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (ctl.add && (count == CNT_W'(CELL_IDX)))
        begin
            valid_next = 1'b1;
            entry_next = new_entry;
        end
        else if (ctl.remove && (IDX_W'(CELL_IDX) >= rm_idx))
        begin
            valid_next = nb_valid;
            entry_next = nb_entry;
        end
    end

    // Search stage: keep the incoming candidate unless this entry wins
    always_comb
    begin
        better = valid_reg && (!cand_in.valid
                 || (entry_reg.prio > cand_in.ent.prio)
                 || ((entry_reg.prio == cand_in.ent.prio)
                     && (entry_reg.ts < cand_in.ent.ts)));
        cand_valid_next = better ? 1'b1 : cand_in.valid;
        cand_ent_next   = better ? entry_reg : cand_in.ent;
        cand_idx_next   = better ? IDX_W'(CELL_IDX) : cand_in_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            cand_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            cand_valid_reg <= cand_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg    <= entry_next;
        cand_ent_reg <= cand_ent_next;
        cand_idx_reg <= cand_idx_next;
    end

    assign valid          = valid_reg;
    assign entry          = entry_reg;
    assign cand_out.valid = cand_valid_reg;
    assign cand_out.ent   = cand_ent_reg;
    assign cand_out_idx   = cand_idx_reg;

endmodule

`default_nettype wire

@@ design/pdq_mcell.sv @@
// Cancel mark cell: one marked task id with its own id compare.
`default_nettype none

module pdq_mcell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire pdq_pkg::mctl_t ctl,
    input  wire logic [15:0]    cmp_id,
    output logic                hit,
    output logic                free
);

    logic        valid_reg, valid_next;
    logic [15:0] id_reg, id_next;

    // Set takes the compared id; clear drops the mark
    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        if (ctl.set)
        begin
            valid_next = 1'b1;
            id_next    = cmp_id;
        end
        else if (ctl.clr)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign hit  = valid_reg && (id_reg == cmp_id);
    assign free = !valid_reg;

endmodule

`default_nettype wire

@@ design/priority_dispatch_queue_with_cancel_unit.sv @@
// Add, cmd 3 and an empty pop go straight to the response state; cancel passes through the
// mark state first. Pop runs the scan state over the search chain of queue cells, then the
// check state tests the head; each cancelled head costs one more scan and check pass.
// One request at a time; the next is taken while the previous result waits in the
// output register. Reset (rst_n low, asynchronous) empties the queue and cancel set.
`default_nettype none

module priority_dispatch_queue_with_cancel_unit #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int CANCEL_DEPTH = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [15:0] task_id,
    input  wire logic [7:0]  priority_req,
    input  wire logic [31:0] timestamp,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [1:0]       status,
    output logic             out_valid,
    output logic [15:0]      out_task_id
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MARK  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_CHECK = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic [15:0]       id_reg, id_next;
    logic [1:0]        pend_status_reg, pend_status_next;
    logic              pend_ovalid_reg, pend_ovalid_next;
    logic [15:0]       pend_id_reg, pend_id_next;
    logic              res_valid_reg, res_valid_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic              res_ovalid_reg, res_ovalid_next;
    logic [15:0]       res_id_reg, res_id_next;

    logic              req_take;
    pdq_pkg::qctl_t    qctl;
    pdq_pkg::entry_t   new_entry;
    logic [IDX_W-1:0]  rm_idx;
    logic [15:0]       cmp_id;
    logic              mark_set_go;
    logic              mark_clr_go;

    logic                   cell_valid [QUEUE_DEPTH];
    pdq_pkg::entry_t        cell_entry [QUEUE_DEPTH];
    pdq_pkg::cand_t         cand       [QUEUE_DEPTH];
    logic [IDX_W-1:0]       cand_idx   [QUEUE_DEPTH];
    pdq_pkg::cand_t         best;
    logic [IDX_W-1:0]       best_idx;

    logic [CANCEL_DEPTH-1:0] hit_vec;
    logic [CANCEL_DEPTH-1:0] free_vec;
    logic [CANCEL_DEPTH-1:0] first_free;
    logic                    any_hit;

    assign req_stall = (state_reg != S_IDLE);
    assign req_take  = req_valid && !req_stall;

    assign new_entry.id   = task_id;
    assign new_entry.prio = priority_req;
    assign new_entry.ts   = timestamp;

    assign best     = cand[QUEUE_DEPTH-1];
    assign best_idx = cand_idx[QUEUE_DEPTH-1];
    assign rm_idx   = best_idx;

    // Queue cells: storage plus registered search chain
    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++)
    begin : g_qcell
        pdq_pkg::cand_t  c_in;
        logic [IDX_W-1:0] c_in_idx;
        logic            n_valid;
        pdq_pkg::entry_t n_entry;

        if (gi == 0)
        begin : g_head
            assign c_in     = '0;
            assign c_in_idx = '0;
        end
        else
        begin : g_body
            assign c_in     = cand[gi-1];
            assign c_in_idx = cand_idx[gi-1];
        end

        if (gi == QUEUE_DEPTH - 1)
        begin : g_tail
            assign n_valid = 1'b0;
            assign n_entry = '0;
        end
        else
        begin : g_mid
            assign n_valid = cell_valid[gi+1];
            assign n_entry = cell_entry[gi+1];
        end

        pdq_qcell #(
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W),
            .CELL_IDX (gi)
        ) u_qcell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (qctl),
            .count        (count_reg),
            .rm_idx       (rm_idx),
            .new_entry    (new_entry),
            .nb_valid     (n_valid),
            .nb_entry     (n_entry),
            .cand_in      (c_in),
            .cand_in_idx  (c_in_idx),
            .valid        (cell_valid[gi]),
            .entry        (cell_entry[gi]),
            .cand_out     (cand[gi]),
            .cand_out_idx (cand_idx[gi])
        );
    end

    // Cancel mark cells
    for (genvar gm = 0; gm < CANCEL_DEPTH; gm++)
    begin : g_mcell
        pdq_pkg::mctl_t mc;

        assign mc.set = mark_set_go && first_free[gm];
        assign mc.clr = mark_clr_go && hit_vec[gm];

        pdq_mcell u_mcell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (mc),
            .cmp_id (cmp_id),
            .hit    (hit_vec[gm]),
            .free   (free_vec[gm])
        );
    end

    // Lowest free mark slot, one-hot
    assign first_free = free_vec & (~free_vec + CANCEL_DEPTH'(1));
    assign any_hit    = |hit_vec;
    assign cmp_id     = (state_reg == S_CHECK) ? best.ent.id : id_reg;

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        scan_cnt_next    = scan_cnt_reg;
        id_next          = id_reg;
        pend_status_next = pend_status_reg;
        pend_ovalid_next = pend_ovalid_reg;
        pend_id_next     = pend_id_reg;
        res_valid_next   = res_valid_reg && res_stall;
        res_status_next  = res_status_reg;
        res_ovalid_next  = res_ovalid_reg;
        res_id_next      = res_id_reg;
        qctl             = '0;
        mark_set_go      = 1'b0;
        mark_clr_go      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    pend_status_next = pdq_pkg::ST_OK;
                    pend_ovalid_next = 1'b0;
                    pend_id_next     = '0;
                    id_next          = task_id;
                    scan_cnt_next    = '0;
                    unique case (pdq_pkg::cmd_t'(cmd))
                        pdq_pkg::CMD_ADD:
                        begin
                            if (count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                pend_status_next = pdq_pkg::ST_QFULL;
                            end
                            else
                            begin
                                qctl.add   = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            state_next = S_RESP;
                        end
                        pdq_pkg::CMD_CANCEL:
                        begin
                            state_next = S_MARK;
                        end
                        pdq_pkg::CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                pend_status_next = pdq_pkg::ST_EMPTY;
                                state_next       = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_MARK:
            begin
                // Already marked ids are accepted unchanged
                if (!any_hit)
                begin
                    if (|free_vec)
                    begin
                        mark_set_go = 1'b1;
                    end
                    else
                    begin
                        pend_status_next = pdq_pkg::ST_CFULL;
                    end
                end
                state_next = S_RESP;
            end
            S_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + IDX_W'(1);
                if (scan_cnt_reg == IDX_W'(QUEUE_DEPTH - 1))
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // Head leaves the queue whether dispatched or cancelled
                qctl.remove   = 1'b1;
                count_next    = count_reg - CNT_W'(1);
                scan_cnt_next = '0;
                if (any_hit)
                begin
                    mark_clr_go = 1'b1;
                    if (count_reg == CNT_W'(1))
                    begin
                        pend_status_next = pdq_pkg::ST_EMPTY;
                        state_next       = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    pend_status_next = pdq_pkg::ST_OK;
                    pend_ovalid_next = 1'b1;
                    pend_id_next     = best.ent.id;
                    state_next       = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = pend_status_reg;
                    res_ovalid_next = pend_ovalid_reg;
                    res_id_next     = pend_id_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_cnt_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_cnt_reg  <= scan_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg          <= id_next;
        pend_status_reg <= pend_status_next;
        pend_ovalid_reg <= pend_ovalid_next;
        pend_id_reg     <= pend_id_next;
        res_status_reg  <= res_status_next;
        res_ovalid_reg  <= res_ovalid_next;
        res_id_reg      <= res_id_next;
    end

    assign res_valid   = res_valid_reg;
    assign status      = res_status_reg;
    assign out_valid   = res_ovalid_reg;
    assign out_task_id = res_id_reg;

endmodule

`default_nettype wire
